// ----- hw/rtl/rtnb_pkg.sv -----
// Shared types, constants and helper functions for the radix tree node builder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rtnb_pkg;

    localparam int CODE_W = 32;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int POS_W  = 14;
    localparam int SIM_W  = 8;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [SIM_W-1:0] sim_t;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_QUERY,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  index;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             valid_res;
        logic [IDX_W-1:0] left_child;
        logic             left_is_leaf;
        logic [IDX_W-1:0] right_child;
        logic             right_is_leaf;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_REQ,
        ST_BASE_RES,
        ST_PROBE_REQ,
        ST_PROBE_RES,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_UP,
        PH_DN,
        PH_GROW,
        PH_HALF,
        PH_SNODE,
        PH_BASEF,
        PH_BIS
    } phase_t;

    // Count of leading zeros of a 32-bit word; 32 for zero.
    function automatic logic [5:0] clz32(input logic [CODE_W-1:0] v);
        logic [5:0] c;
        c = 6'd32;
        for (int k = 0; k < CODE_W; k++)
        begin
            if (v[k])
            begin
                c = 6'(CODE_W - 1 - k);
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/rtnb_if.sv -----
// Handshake channel interfaces for the radix tree node builder.
// Depends on rtnb_pkg for field widths.
`timescale 1ns / 1ps

interface rtnb_in_if
    import rtnb_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] code;

    modport source (output valid, output action, output index, output code, input ready);
    modport sink   (input valid, input action, input index, input code, output ready);
endinterface

interface rtnb_out_if
    import rtnb_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node;
    logic             valid_res;
    logic [IDX_W-1:0] left_child;
    logic             left_is_leaf;
    logic [IDX_W-1:0] right_child;
    logic             right_is_leaf;

    modport source (output valid, output node, output valid_res, output left_child,
                    output left_is_leaf, output right_child, output right_is_leaf,
                    input ready);
    modport sink   (input valid, input node, input valid_res, input left_child,
                    input left_is_leaf, input right_child, input right_is_leaf,
                    output ready);
endinterface

interface rtnb_cfg_if
    import rtnb_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rtnb_front.sv -----
// Front end: accepts input words and classifies them for the back end.
// Depends on rtnb_pkg and rtnb_in_if.
`timescale 1ns / 1ps

module rtnb_front
    import rtnb_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
)
(
    rtnb_in_if.sink         items,
    input  logic [CNT_W-1:0] n,
    output logic            push_valid,
    input  logic            push_ready,
    output entry_t          push_entry
);

    logic drop;

    always_comb
    begin
        push_entry.index = items.index;
        push_entry.code  = items.code;
        drop             = 1'b0;
        if (!items.action)
        begin
            push_entry.kind = KIND_LOAD;
            // Loads beyond the store are taken and discarded.
            drop = !(32'(items.index) < MAX_LEAVES);
        end
        else if (n < CNT_W'(2) || {1'b0, items.index} >= (n - CNT_W'(1)))
        begin
            push_entry.kind = KIND_EMPTY;
        end
        else
        begin
            push_entry.kind = KIND_QUERY;
        end
    end

    assign push_valid  = items.valid && !drop;
    assign items.ready = push_ready;

endmodule

// ----- hw/rtl/rtnb_queue.sv -----
// Two-entry queue between the front end and the back end.
// Depends on rtnb_pkg for the entry type.
`timescale 1ns / 1ps

module rtnb_queue
    import rtnb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop,
    output entry_t pop_entry
);

    entry_t     ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ (pop && pop_valid);
        count_next  = count_reg + 2'(do_push) - 2'(pop && pop_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/rtnb_back.sv -----
// Back end: code store, query sequencer and result register.
// Depends on rtnb_pkg and rtnb_out_if.
`timescale 1ns / 1ps

module rtnb_back
    import rtnb_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] n,
    input  logic             pop_valid,
    output logic             pop,
    input  entry_t           pop_entry,
    rtnb_out_if.source       results
);

    localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;

    logic [CODE_W-1:0] mem [MAX_LEAVES];
    logic [CODE_W-1:0] rd_data;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;

    state_t  state_reg, state_next;
    phase_t  phase_reg, phase_next;
    pos_t    i_reg, i_next;
    pos_t    base_reg, base_next;
    pos_t    q_reg, q_next;
    pos_t    lmax_reg, lmax_next;
    pos_t    l_reg, l_next;
    pos_t    t_reg, t_next;
    pos_t    first_reg, first_next;
    pos_t    last_reg, last_next;
    pos_t    lo_reg, lo_next;
    pos_t    hi_reg, hi_next;
    logic    dpos_reg, dpos_next;
    sim_t    s1_reg, s1_next;
    sim_t    smin_reg, smin_next;
    sim_t    snode_reg, snode_next;
    logic    oor_reg, oor_next;
    logic [CODE_W-1:0] base_code_reg, base_code_next;
    result_t pend_reg, pend_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    res_load;

    pos_t    n_pos;
    sim_t    sim;
    logic [POS_W-1:0] pq_x;
    logic    gt_smin;
    logic    gt_snode;
    pos_t    lo_new, hi_new, l_new, t_new, lmax_new;
    logic    bis_more;
    logic    dpos_new;

    function automatic logic [AW-1:0] to_addr(input pos_t p);
        return AW'(p[CNT_W-1:0]);
    endfunction

    function automatic pos_t step(input pos_t base, input logic up, input pos_t x);
        return up ? (base + x) : (base - x);
    endfunction

    assign n_pos = pos_t'(n);

    // Similarity of the base position and the probed position.
    always_comb
    begin
        pq_x = base_reg ^ q_reg;
        if (oor_reg)
        begin
            sim = -SIM_W'(1);
        end
        else if (base_code_reg == rd_data)
        begin
            sim = SIM_W'(clz32(32'(pq_x))) + SIM_W'(32);
        end
        else
        begin
            sim = SIM_W'(clz32(base_code_reg ^ rd_data));
        end
        gt_smin  = sim > smin_reg;
        gt_snode = sim > snode_reg;
        lo_new   = gt_snode ? (q_reg + pos_t'(1)) : lo_reg;
        hi_new   = gt_snode ? hi_reg : (q_reg - pos_t'(1));
        bis_more = lo_new <= hi_new;
        l_new    = gt_smin ? (l_reg + t_reg) : l_reg;
        t_new    = t_reg >>> 1;
        lmax_new = lmax_reg <<< 1;
        dpos_new = s1_reg > sim;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    priority case (pop_entry.kind)
                        KIND_QUERY: state_next = ST_BASE_REQ;
                        KIND_EMPTY: state_next = ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BASE_REQ:  state_next = ST_BASE_RES;
            ST_BASE_RES:  state_next = ST_PROBE_REQ;
            ST_PROBE_REQ: state_next = ST_PROBE_RES;
            ST_PROBE_RES:
            begin
                priority if (phase_reg == PH_SNODE)
                begin
                    state_next = ST_BASE_REQ;
                end
                else if (phase_reg == PH_BIS && !bis_more)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PROBE_REQ;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        phase_next     = phase_reg;
        i_next         = i_reg;
        base_next      = base_reg;
        q_next         = q_reg;
        lmax_next      = lmax_reg;
        l_next         = l_reg;
        t_next         = t_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        dpos_next      = dpos_reg;
        s1_next        = s1_reg;
        smin_next      = smin_reg;
        snode_next     = snode_reg;
        oor_next       = oor_reg;
        base_code_next = base_code_reg;
        pend_next      = pend_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        res_load       = 1'b0;
        rd_addr        = to_addr(base_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    pop       = 1'b1;
                    mem_we    = (pop_entry.kind == KIND_LOAD);
                    i_next    = pos_t'(pop_entry.index);
                    base_next = pos_t'(pop_entry.index);
                    phase_next = PH_INIT;
                    pend_next = '0;
                    pend_next.node = pop_entry.index;
                end
            end
            ST_BASE_REQ:
            begin
                rd_addr = to_addr(base_reg);
            end
            ST_BASE_RES:
            begin
                base_code_next = rd_data;
                if (phase_reg == PH_INIT)
                begin
                    q_next     = i_reg + pos_t'(1);
                    phase_next = PH_UP;
                end
                else
                begin
                    q_next     = (lo_reg + hi_reg) >>> 1;
                    phase_next = PH_BIS;
                end
            end
            ST_PROBE_REQ:
            begin
                rd_addr  = to_addr(q_reg);
                oor_next = (q_reg < pos_t'(0)) || (q_reg >= n_pos);
            end
            ST_PROBE_RES:
            begin
                unique case (phase_reg)
                    PH_UP:
                    begin
                        s1_next    = sim;
                        q_next     = i_reg - pos_t'(1);
                        phase_next = PH_DN;
                    end
                    PH_DN:
                    begin
                        // The neighbor away from the direction sets the bound.
                        dpos_next  = dpos_new;
                        smin_next  = dpos_new ? sim : s1_reg;
                        lmax_next  = pos_t'(2);
                        q_next     = step(i_reg, dpos_new, pos_t'(2));
                        phase_next = PH_GROW;
                    end
                    PH_GROW:
                    begin
                        if (gt_smin)
                        begin
                            lmax_next = lmax_new;
                            q_next    = step(i_reg, dpos_reg, lmax_new);
                        end
                        else
                        begin
                            t_next     = lmax_reg >>> 1;
                            l_next     = '0;
                            q_next     = step(i_reg, dpos_reg, lmax_reg >>> 1);
                            phase_next = PH_HALF;
                        end
                    end
                    PH_HALF:
                    begin
                        l_next = l_new;
                        t_next = t_new;
                        if (t_new != pos_t'(0))
                        begin
                            q_next = step(i_reg, dpos_reg, l_new + t_new);
                        end
                        else
                        begin
                            q_next     = step(i_reg, dpos_reg, l_new);
                            phase_next = PH_SNODE;
                        end
                    end
                    PH_SNODE:
                    begin
                        snode_next = sim;
                        first_next = (i_reg < q_reg) ? i_reg : q_reg;
                        last_next  = (i_reg < q_reg) ? q_reg : i_reg;
                        lo_next    = (i_reg < q_reg) ? i_reg : q_reg;
                        hi_next    = (i_reg < q_reg) ? q_reg : i_reg;
                        base_next  = (i_reg < q_reg) ? i_reg : q_reg;
                        phase_next = PH_BASEF;
                    end
                    PH_BIS:
                    begin
                        lo_next = lo_new;
                        hi_next = hi_new;
                        if (bis_more)
                        begin
                            q_next = (lo_new + hi_new) >>> 1;
                        end
                        else
                        begin
                            pend_next.valid_res     = 1'b1;
                            pend_next.left_child    = hi_new[IDX_W-1:0];
                            pend_next.left_is_leaf  = (first_reg == hi_new);
                            pend_next.right_child   = IDX_W'(hi_new + pos_t'(1));
                            pend_next.right_is_leaf = (last_reg == hi_new + pos_t'(1));
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            ST_OUT:
            begin
                res_load = !res_valid_reg || results.ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(pop_entry.index)] <= pop_entry.code;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        base_reg      <= base_next;
        q_reg         <= q_next;
        lmax_reg      <= lmax_next;
        l_reg         <= l_next;
        t_reg         <= t_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        dpos_reg      <= dpos_next;
        s1_reg        <= s1_next;
        smin_reg      <= smin_next;
        snode_reg     <= snode_next;
        oor_reg       <= oor_next;
        base_code_reg <= base_code_next;
        pend_reg      <= pend_next;
        if (res_load)
        begin
            res_reg <= pend_reg;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.node          = res_reg.node;
    assign results.valid_res     = res_reg.valid_res;
    assign results.left_child    = res_reg.left_child;
    assign results.left_is_leaf  = res_reg.left_is_leaf;
    assign results.right_child   = res_reg.right_child;
    assign results.right_is_leaf = res_reg.right_is_leaf;

endmodule

// ----- hw/rtl/radix_tree_node_builder.sv -----
// Radix tree node builder: stores sorted codes and answers internal node queries.
// A load word is written to the code store from the idle state. Each store probe of a
// query passes through a request state and a response state; the code store has a
// single read port. A two-entry queue decouples input acceptance from the sequencer.
// Reset clears control state and sets leaf_count to 2; the code store is not cleared.
// Depends on rtnb_pkg, the rtnb interfaces, rtnb_front, rtnb_queue and rtnb_back.
`timescale 1ns / 1ps

module radix_tree_node_builder
    import rtnb_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    rtnb_cfg_if.sink  cfg,
    rtnb_in_if.sink   items,
    rtnb_out_if.source results
);

    logic [CNT_W-1:0] leaf_count_reg;
    logic [CNT_W-1:0] n;
    logic             push_valid;
    logic             push_ready;
    entry_t           push_entry;
    logic             pop_valid;
    logic             pop;
    entry_t           pop_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= CNT_W'(2);
        end
        else if (cfg.valid)
        begin
            leaf_count_reg <= cfg.data;
        end
    end

    // Leaf counts beyond the store size count as the store size.
    assign n = (32'(leaf_count_reg) > MAX_LEAVES) ? CNT_W'(MAX_LEAVES) : leaf_count_reg;

    rtnb_front #(.MAX_LEAVES(MAX_LEAVES)) u_front (
        .items      (items),
        .n          (n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    rtnb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    rtnb_back #(.MAX_LEAVES(MAX_LEAVES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_entry (pop_entry),
        .results   (results)
    );

endmodule
